// ----- design/assert_macros.svh -----
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock outside reset
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- design/mvpid_pkg.sv -----
// types and constants of the motor velocity pid
`default_nettype none
package mvpid_pkg;
  localparam int FRAC_BITS = 16;
  localparam int VEL_W = 22;
  localparam int DT_W = 20;
  localparam int GAIN_W = 26;
  localparam int CFG_W = 26;
  localparam int CFG_IDX_W = 3;
  localparam int DRIVE_W = 8;
  localparam int NEUTRAL = 125;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MAX = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MIN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_REJECT = 3'd6;

  typedef struct packed {
    logic signed [VEL_W-1:0] target_velocity;
    logic signed [VEL_W-1:0] sensed_velocity;
    logic [DT_W-1:0] time_step;
  } mvpid_in_t;

  typedef struct packed {
    logic [DRIVE_W-1:0] drive_byte;
    logic hit_max;
    logic hit_min;
    logic sample_rejected;
    logic signed [VEL_W-1:0] smoothed_velocity;
  } mvpid_out_t;

  typedef struct packed {
    logic start;
    logic busy;
  } mvpid_mul_ctl_t;
endpackage
`default_nettype wire

// ----- design/mvpid_if.sv -----
// valid-ready channel interface
`default_nettype none
interface mvpid_if #(parameter int W = 8);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- design/mvpid_mul.sv -----
// bit-serial signed multiplier, one multiplier bit per cycle
`default_nettype none
module mvpid_mul #(
  parameter int AW = 27,
  parameter int BW = 44
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire logic signed [AW-1:0] a,
  input  wire logic signed [BW-1:0] b,
  output logic busy,
  output logic signed [AW+BW-1:0] prod
);
  localparam int CW = $clog2(BW + 1);
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic signed [AW+BW-1:0] acc_r, acc_nxt, mc_r, mc_nxt;
  logic [BW-1:0] mq_r, mq_nxt;
  logic busy_r, busy_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    acc_nxt = acc_r;
    mc_nxt = mc_r;
    mq_nxt = mq_r;
    busy_nxt = busy_r;
    if (start) begin
      acc_nxt = '0;
      mc_nxt = (AW+BW)'(a);
      mq_nxt = b;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (mq_r[0]) begin
        if (cnt_r == CW'(BW - 1)) acc_nxt = acc_r - mc_r;
        else acc_nxt = acc_r + mc_r;
      end
      mc_nxt = mc_r <<< 1;
      mq_nxt = mq_r >> 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(BW - 1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    mc_r <= mc_nxt;
    mq_r <= mq_nxt;
  end

  assign busy = busy_r | start;
  assign prod = acc_r;
endmodule
`default_nettype wire

// ----- design/mvpid_div.sv -----
// restoring divider, one quotient bit per cycle, truncates toward zero
`default_nettype none
module mvpid_div #(
  parameter int NW = 70,
  parameter int DW = 20
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire logic signed [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic busy,
  output logic signed [NW-1:0] quo
);
  localparam int CW = $clog2(NW + 1);
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0] q_r, q_nxt;
  logic [DW:0] rem_r, rem_nxt, trial;
  logic [DW-1:0] den_r, den_nxt;
  logic neg_r, neg_nxt, busy_r, busy_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    q_nxt = q_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    neg_nxt = neg_r;
    busy_nxt = busy_r;
    trial = {rem_r[DW-1:0], q_r[NW-1]};
    if (start) begin
      neg_nxt = num[NW-1];
      q_nxt = num[NW-1] ? NW'(-num) : NW'(num);
      rem_nxt = '0;
      den_nxt = den;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt = {q_r[NW-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial;
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(NW - 1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign busy = busy_r | start;
  assign quo = neg_r ? -$signed(q_r) : $signed(q_r);
endmodule
`default_nettype wire

// ----- design/motor_velocity_pid.sv -----
// motor velocity pid controller, top level
// Use: one request on the in_ channel per control tick carries target_velocity,
// sensed_velocity and time_step; one result comes out on the out_ channel with
// drive_byte, the clamp flags, sample_rejected and smoothed_velocity.
// Gains and limits must be written by the user through the cfg_ port only while the
// block is idle; the block itself does not enforce it. Smoothing and the stop test
// are done in S_FILT, then a shared bit-serial multiplier (four products, two
// while the integral is held) and a bit-serial divider for the derivative term
// (skipped for a zero time_step) run in turn. A rejected or neutral tick goes
// straight from S_FILT to S_OUT. One request is worked on at a time; the next
// is taken the cycle after the result has been delivered.
// Reset clears the history, the integral, the held drive and flags and sets
// the registers to their reset values (deadband 9, max 250, limit 20.0).
// When the receiver stalls, the result is held in the output register and
// no new request is taken until it has been delivered.
`default_nettype none
module motor_velocity_pid (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cfg_we,
  input  wire logic [mvpid_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mvpid_pkg::CFG_W-1:0] cfg_data,
  mvpid_if.sink in_ch,
  mvpid_if.source out_ch
);
  import mvpid_pkg::*;
  `include "assert_macros.svh"

  localparam int MAW = 27;
  localparam int MBW = 44;
  localparam int PW = MAW + MBW;
  localparam int AW = 24 + FRAC_BITS;
  localparam int DNW = 70;
  localparam logic [3:0] S_IDLE = 4'd0, S_FILT = 4'd1, S_PM = 4'd2, S_PW = 4'd3,
    S_IM = 4'd4, S_IW = 4'd5, S_TM = 4'd6, S_TW = 4'd7, S_DM = 4'd8,
    S_DW = 4'd9, S_DV = 4'd10, S_DVW = 4'd11, S_FIN = 4'd12, S_OUT = 4'd13;

  logic [GAIN_W-1:0] gain_p_r, gain_i_r, gain_d_r;
  logic [6:0] dead_r;
  logic [DRIVE_W-1:0] dmax_r, dmin_r, held_drive_r, held_drive_nxt;
  logic [20:0] rej_r;
  logic [3:0] st_r, st_nxt;
  mvpid_in_t req_r, req_nxt;
  mvpid_out_t res_r, res_nxt;
  logic out_v_r, out_v_nxt;
  logic signed [VEL_W-1:0] h0_r, h1_r, h2_r, h0_nxt, h1_nxt, h2_nxt;
  logic signed [VEL_W-1:0] hs_r, hs_nxt;
  logic signed [AW-1:0] integ_r, integ_nxt;
  logic windup_r, windup_nxt, skip_r, skip_nxt, mxf_r, mxf_nxt, mnf_r, mnf_nxt;
  logic signed [PW-1:0] p_r, p_nxt, d_r, d_nxt, t_r, t_nxt;

  logic m_start, m_busy, dv_start, dv_busy;
  logic signed [MAW-1:0] m_a;
  logic signed [MBW-1:0] m_b;
  logic signed [PW-1:0] m_prod;
  logic signed [DNW-1:0] dv_quo;
  mvpid_mul_ctl_t mctl;

  logic signed [VEL_W+1:0] ssum, sflt;
  logic signed [VEL_W:0] sabs;
  logic [VEL_W+1:0] habs;
  logic rej, near;
  logic signed [VEL_W-1:0] snew;
  logic signed [VEL_W:0] err;
  logic signed [PW:0] isum, pid, vv, vabs;
  logic signed [PW:0] rr, rc;
  logic signed [PW-1:0] tshift;

  mvpid_mul #(.AW(MAW), .BW(MBW)) u_mul (
    .clk, .rst_n, .start(m_start), .a(m_a), .b(m_b), .busy(m_busy), .prod(m_prod)
  );
  mvpid_div #(.NW(DNW), .DW(DT_W)) u_div (
    .clk, .rst_n, .start(dv_start), .num(DNW'(d_r)), .den(req_r.time_step),
    .busy(dv_busy), .quo(dv_quo)
  );
  assign mctl = '{start: m_start, busy: m_busy};

  always_comb begin
    sabs = req_r.sensed_velocity[VEL_W-1] ? -(VEL_W+1)'(req_r.sensed_velocity)
                                          : (VEL_W+1)'(req_r.sensed_velocity);
    rej = sabs > $signed({2'b00, rej_r});
    ssum = (VEL_W+2)'(req_r.sensed_velocity) + ((VEL_W+2)'(h0_r) <<< 1)
         + (VEL_W+2)'(h1_r) + (VEL_W+2)'(2);
    sflt = ssum >>> 2;
    if (sflt > (VEL_W+2)'(2**(VEL_W-1) - 1)) snew = {1'b0, {(VEL_W-1){1'b1}}};
    else if (sflt < -(VEL_W+2)'(2**(VEL_W-1))) snew = {1'b1, {(VEL_W-1){1'b0}}};
    else snew = sflt[VEL_W-1:0];
    habs = (h0_r[VEL_W-1] ? -(VEL_W+2)'(h0_r) : (VEL_W+2)'(h0_r))
         + (h1_r[VEL_W-1] ? -(VEL_W+2)'(h1_r) : (VEL_W+2)'(h1_r))
         + (h2_r[VEL_W-1] ? -(VEL_W+2)'(h2_r) : (VEL_W+2)'(h2_r));
    near = ((VEL_W+10)'(habs) * (VEL_W+10)'(100)) < (VEL_W+10)'(9 << FRAC_BITS);
    err = (VEL_W+1)'(req_r.target_velocity) - (VEL_W+1)'(hs_r);
    tshift = t_r >>> FRAC_BITS;
    isum = (PW+1)'(integ_r) + ((PW+1)'(m_prod) >>> FRAC_BITS);
    pid = (PW+1)'(p_r) + (PW+1)'(integ_r) + (PW+1)'(d_r);
    vv = pid + (PW+1)'(NEUTRAL << FRAC_BITS);
    vabs = vv[PW] ? -vv : vv;
    rr = (vabs + (PW+1)'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (vv[PW]) rr = -rr;
    if (rr > (PW+1)'(NEUTRAL)) rr = rr + (PW+1)'(dead_r);
    else if (rr < (PW+1)'(NEUTRAL)) rr = rr - (PW+1)'(dead_r);
  end

  always_comb begin
    st_nxt = st_r;
    req_nxt = req_r;
    res_nxt = res_r;
    out_v_nxt = out_v_r;
    {h0_nxt, h1_nxt, h2_nxt, hs_nxt} = {h0_r, h1_r, h2_r, hs_r};
    integ_nxt = integ_r;
    windup_nxt = windup_r;
    skip_nxt = skip_r;
    mxf_nxt = mxf_r;
    mnf_nxt = mnf_r;
    held_drive_nxt = held_drive_r;
    p_nxt = p_r;
    d_nxt = d_r;
    t_nxt = t_r;
    m_start = 1'b0;
    m_a = '0;
    m_b = '0;
    dv_start = 1'b0;
    rc = rr;
    if (out_v_r && out_ch.ready) out_v_nxt = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (in_ch.valid && !out_v_r) begin
          req_nxt = in_ch.data;
          st_nxt = S_FILT;
        end
      end
      S_FILT: begin
        if (near) integ_nxt = '0;
        skip_nxt = rej;
        if (!rej) begin
          hs_nxt = snew;
          h2_nxt = h1_r;
          h1_nxt = h0_r;
          h0_nxt = snew;
        end
        res_nxt.sample_rejected = rej;
        res_nxt.smoothed_velocity = rej ? hs_r : snew;
        if (near && req_r.target_velocity == '0) begin
          res_nxt.drive_byte = DRIVE_W'(NEUTRAL);
          res_nxt.hit_max = 1'b0;
          res_nxt.hit_min = 1'b0;
          st_nxt = S_OUT;
        end else if (rej) begin
          res_nxt.drive_byte = held_drive_r;
          res_nxt.hit_max = mxf_r;
          res_nxt.hit_min = mnf_r;
          st_nxt = S_OUT;
        end else begin
          st_nxt = S_PM;
        end
      end
      S_PM: begin
        m_start = 1'b1;
        m_a = MAW'(gain_p_r);
        m_b = MBW'(err);
        st_nxt = S_PW;
      end
      S_PW: if (!mctl.busy) begin
        p_nxt = m_prod >>> FRAC_BITS;
        st_nxt = windup_r ? S_DM : S_IM;
      end
      S_IM: begin
        m_start = 1'b1;
        m_a = MAW'(gain_i_r);
        m_b = MBW'(err);
        st_nxt = S_IW;
      end
      S_IW: if (!mctl.busy) begin
        t_nxt = m_prod;
        st_nxt = S_TM;
      end
      S_TM: begin
        m_start = 1'b1;
        m_a = MAW'({1'b0, req_r.time_step});
        m_b = MBW'(tshift);
        st_nxt = S_TW;
      end
      S_TW: if (!mctl.busy) begin
        if (isum > (PW+1)'((64'sd1 <<< (AW-1)) - 64'sd1))
          integ_nxt = {1'b0, {(AW-1){1'b1}}};
        else if (isum < -((PW+1)'(64'sd1 <<< (AW-1))))
          integ_nxt = {1'b1, {(AW-1){1'b0}}};
        else integ_nxt = isum[AW-1:0];
        st_nxt = S_DM;
      end
      S_DM: begin
        m_start = 1'b1;
        m_a = MAW'(gain_d_r);
        m_b = MBW'((VEL_W+1)'(h0_r) - (VEL_W+1)'(h1_r));
        st_nxt = S_DW;
      end
      S_DW: if (!mctl.busy) begin
        d_nxt = m_prod;
        st_nxt = (req_r.time_step == '0) ? S_FIN : S_DV;
        if (req_r.time_step == '0) d_nxt = '0;
      end
      S_DV: begin
        dv_start = 1'b1;
        st_nxt = S_DVW;
      end
      S_DVW: if (!dv_busy) begin
        d_nxt = PW'(dv_quo);
        st_nxt = S_FIN;
      end
      S_FIN: begin
        windup_nxt = (pid[PW] ? -pid : pid) > (PW+1)'(NEUTRAL << FRAC_BITS);
        mxf_nxt = 1'b0;
        mnf_nxt = 1'b0;
        if (rc > (PW+1)'($signed({1'b0, dmax_r}))) begin
          rc = (PW+1)'($signed({1'b0, dmax_r}));
          mxf_nxt = 1'b1;
        end
        if (rc < (PW+1)'($signed({1'b0, dmin_r}))) begin
          rc = (PW+1)'($signed({1'b0, dmin_r}));
          mnf_nxt = 1'b1;
        end
        held_drive_nxt = rc[DRIVE_W-1:0];
        res_nxt.drive_byte = rc[DRIVE_W-1:0];
        res_nxt.hit_max = mxf_nxt;
        res_nxt.hit_min = mnf_nxt;
        st_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_v_nxt) begin
          out_v_nxt = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      out_v_r <= 1'b0;
      {h0_r, h1_r, h2_r, hs_r} <= '0;
      integ_r <= '0;
      {windup_r, skip_r, mxf_r, mnf_r} <= '0;
      held_drive_r <= '0;
      gain_p_r <= '0;
      gain_i_r <= '0;
      gain_d_r <= '0;
      dead_r <= 7'd9;
      dmax_r <= 8'd250;
      dmin_r <= 8'd0;
      rej_r <= 21'(20 << FRAC_BITS);
    end else begin
      st_r <= st_nxt;
      out_v_r <= out_v_nxt;
      {h0_r, h1_r, h2_r, hs_r} <= {h0_nxt, h1_nxt, h2_nxt, hs_nxt};
      integ_r <= integ_nxt;
      {windup_r, skip_r, mxf_r, mnf_r} <= {windup_nxt, skip_nxt, mxf_nxt, mnf_nxt};
      held_drive_r <= held_drive_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_GAIN_P: gain_p_r <= cfg_data[GAIN_W-1:0];
          REG_GAIN_I: gain_i_r <= cfg_data[GAIN_W-1:0];
          REG_GAIN_D: gain_d_r <= cfg_data[GAIN_W-1:0];
          REG_DEADBAND: dead_r <= cfg_data[6:0];
          REG_DRIVE_MAX: dmax_r <= cfg_data[DRIVE_W-1:0];
          REG_DRIVE_MIN: dmin_r <= cfg_data[DRIVE_W-1:0];
          REG_REJECT: rej_r <= cfg_data[20:0];
          default: ;
        endcase
      end
    end
    req_r <= req_nxt;
    res_r <= res_nxt;
    p_r <= p_nxt;
    d_r <= d_nxt;
    t_r <= t_nxt;
  end

  assign in_ch.ready = (st_r == S_IDLE) && !out_v_r;
  assign out_ch.valid = out_v_r;
  assign out_ch.data = res_r;

  `ASSERT_IMP(a_one_at_a_time, out_v_r && st_r != S_IDLE, st_r != S_FILT)
  `ASSERT_NEXT(a_hold_res, out_v_r && !out_ch.ready, $stable(res_r))
  `ASSERT_IMP(a_div_mul_excl, dv_busy, !m_busy)
endmodule
`default_nettype wire

// ----- bench/tb.sv -----
// testbench of the motor velocity pid: directed and random control ticks checked against a predictor
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mvpid_pkg::*;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  mvpid_if #(.W($bits(mvpid_in_t))) in_bus();
  mvpid_if #(.W($bits(mvpid_out_t))) out_bus();

  motor_velocity_pid u_top (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_ch(in_bus),
    .out_ch(out_bus)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // register mirror
  longint kp, ki, kd, dband, dmax, dmin, rlim;
  // controller state mirror
  longint hist [3];
  longint integ, hdrive, hsmooth;
  bit wind, skip, mflag, nflag;

  mvpid_out_t drive_q[$];
  int fails;
  bit calm;
  int stall;

  function automatic longint iabs(longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic void smooth_sample(longint v);
    longint s;
    if (iabs(v) > rlim) begin
      skip = 1'b1;
      return;
    end
    skip = 1'b0;
    s = (v + 2 * hist[0] + hist[1] + 2) >>> 2;
    if (s > 2097151) s = 2097151;
    if (s < -2097152) s = -2097152;
    hsmooth = s;
    hist[2] = hist[1];
    hist[1] = hist[0];
    hist[0] = s;
  endfunction

  function automatic mvpid_out_t pack_drive(longint drv, bit hmax, bit hmin);
    mvpid_out_t o;
    o.drive_byte = drv[7:0];
    o.hit_max = hmax;
    o.hit_min = hmin;
    o.sample_rejected = skip;
    o.smoothed_velocity = hsmooth[VEL_W-1:0];
    return o;
  endfunction

  function automatic mvpid_out_t control_tick(mvpid_in_t req);
    longint tgt, sen, dt, err, p, t, d, pid, v, r;
    longint one;
    longint ilim;
    one = 64'sd1 <<< 16;
    ilim = 64'sd1 <<< 39;
    tgt = longint'(req.target_velocity);
    sen = longint'(req.sensed_velocity);
    dt = longint'({1'b0, req.time_step});
    if (100 * (iabs(hist[0]) + iabs(hist[1]) + iabs(hist[2])) < 9 * one) begin
      integ = 0;
      if (tgt == 0) begin
        smooth_sample(sen);
        return pack_drive(NEUTRAL, 1'b0, 1'b0);
      end
    end
    smooth_sample(sen);
    if (skip) return pack_drive(hdrive, mflag, nflag);
    err = tgt - hsmooth;
    p = (kp * err) >>> 16;
    if (!wind) begin
      t = (ki * err) >>> 16;
      integ += (t * dt) >>> 16;
      if (integ > ilim - 1) integ = ilim - 1;
      if (integ < -ilim) integ = -ilim;
    end
    d = 0;
    if (dt != 0) d = (kd * (hist[0] - hist[1])) / dt;
    pid = p + integ + d;
    wind = iabs(pid) > NEUTRAL * one;
    v = pid + NEUTRAL * one;
    r = (iabs(v) + (one >>> 1)) >>> 16;
    if (v < 0) r = -r;
    if (r > NEUTRAL) r += dband;
    else if (r < NEUTRAL) r -= dband;
    mflag = 1'b0;
    nflag = 1'b0;
    if (r > dmax) begin
      r = dmax;
      mflag = 1'b1;
    end
    if (r < dmin) begin
      r = dmin;
      nflag = 1'b1;
    end
    hdrive = r & 255;
    return pack_drive(hdrive, mflag, nflag);
  endfunction

  // result side: random stalls and field checks
  always @(posedge clk) begin
    mvpid_out_t got, want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      stall = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        got = out_bus.data;
        if (drive_q.size() == 0) begin
          $error("unexpected result");
          fails++;
        end else begin
          want = drive_q.pop_front();
          if (got.drive_byte !== want.drive_byte) begin
            $error("drive_byte exp %0d got %0d", want.drive_byte, got.drive_byte);
            fails++;
          end
          if (got.hit_max !== want.hit_max) begin
            $error("hit_max exp %0d got %0d", want.hit_max, got.hit_max);
            fails++;
          end
          if (got.hit_min !== want.hit_min) begin
            $error("hit_min exp %0d got %0d", want.hit_min, got.hit_min);
            fails++;
          end
          if (got.sample_rejected !== want.sample_rejected) begin
            $error("sample_rejected exp %0d got %0d", want.sample_rejected,
                   got.sample_rejected);
            fails++;
          end
          if (got.smoothed_velocity !== want.smoothed_velocity) begin
            $error("smoothed_velocity exp %0d got %0d", want.smoothed_velocity,
                   got.smoothed_velocity);
            fails++;
          end
        end
        stall = calm ? 0 : $urandom_range(0, 6);
      end
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        stall--;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  task automatic send_tick(longint tgt, longint sen, longint dt);
    int gap;
    mvpid_in_t req;
    gap = calm ? 0 : $urandom_range(0, 6);
    req.target_velocity = tgt[VEL_W-1:0];
    req.sensed_velocity = sen[VEL_W-1:0];
    req.time_step = dt[DT_W-1:0];
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.data <= req;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    drive_q.push_back(control_tick(req));
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (drive_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_W-1:0];
    @(posedge clk);
    case (idx)
      REG_GAIN_P: kp = val;
      REG_GAIN_I: ki = val;
      REG_GAIN_D: kd = val;
      REG_DEADBAND: dband = val;
      REG_DRIVE_MAX: dmax = val;
      REG_DRIVE_MIN: dmin = val;
      default: rlim = val;
    endcase
  endtask

  task automatic load_regs(longint p, longint i, longint d, longint db, longint mx,
                           longint mn, longint lim);
    drain();
    write_reg(REG_GAIN_P, p);
    write_reg(REG_GAIN_I, i);
    write_reg(REG_GAIN_D, d);
    write_reg(REG_DEADBAND, db);
    write_reg(REG_DRIVE_MAX, mx);
    write_reg(REG_DRIVE_MIN, mn);
    write_reg(REG_REJECT, lim);
    cfg_we <= 1'b0;
  endtask

  function automatic longint rand_vel(longint mag);
    return longint'($urandom_range(0, 2 * mag)) - mag;
  endfunction

  task automatic test_reset_defaults();
    send_tick(0, 0, 655);
    send_tick(0, 30 << 16, 655);
    send_tick(0, -(30 << 16), 655);
    send_tick(2 << 16, 1 << 16, 655);
    send_tick(-(2 << 16), 25 << 16, 0);
  endtask

  task automatic test_directed_extremes();
    load_regs(67108863, 67108863, 67108863, 125, 255, 0, 2097151);
    send_tick(2097151, 2097151, 1048575);
    send_tick(-2097152, -2097152, 1048575);
    send_tick(-2097152, 2097151, 0);
    send_tick(2097151, -2097151, 1);
    send_tick(0, 0, 0);
    load_regs(10 << 16, 2 << 16, 1 << 16, 0, 0, 255, 1 << 16);
    send_tick(3 << 16, 1 << 15, 655);
    send_tick(-(3 << 16), -(1 << 15), 655);
    send_tick(1 << 16, (1 << 16) + 1, 655);
    send_tick(0, 0, 655);
    load_regs(1 << 16, 1 << 14, 1 << 12, 9, 250, 0, 20 << 16);
    repeat (6) send_tick(0, 0, 655);
    send_tick(1 << 10, 0, 655);
    send_tick(0, 1 << 16, 655);
    send_tick(0, 0, 655);
  endtask

  task automatic test_random_phases();
    longint tgt, sen, dt, p, i, d, db, mx, mn, lim;
    int kind;
    for (int ph = 0; ph < 8; ph++) begin
      p = (ph == 0) ? 67108863 : (ph == 1) ? 0 : $urandom_range(0, 40 << 16);
      i = (ph == 0) ? 67108863 : (ph == 1) ? 0 : $urandom_range(0, 20 << 16);
      d = (ph == 0) ? 67108863 : (ph == 1) ? 0 : $urandom_range(0, 4 << 16);
      db = (ph == 2) ? 125 : (ph == 3) ? 0 : $urandom_range(0, 20);
      mx = (ph == 2) ? 0 : (ph == 3) ? 255 : $urandom_range(180, 255);
      mn = (ph == 2) ? 255 : (ph == 3) ? 0 : $urandom_range(0, 70);
      lim = (ph == 4) ? 2097151 : (ph == 5) ? 0 : $urandom_range(1 << 16, 2097151);
      load_regs(p, i, d, db, mx, mn, lim);
      calm = (ph == 6);
      tgt = rand_vel(3 << 16);
      for (int n = 0; n < 100; n++) begin
        kind = $urandom_range(0, 9);
        dt = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(65, 3277);
        if (kind < 6) begin
          if ($urandom_range(0, 19) == 0) tgt = rand_vel(3 << 16);
          sen = tgt + rand_vel(2 << 16);
        end else if (kind == 6) begin
          tgt = 0;
          sen = rand_vel(1000);
        end else if (kind == 7) begin
          sen = ($urandom_range(0, 1) ? 1 : -1) * (lim + $urandom_range(1, 1 << 16));
        end else begin
          tgt = rand_vel(2097152);
          sen = rand_vel(2097152);
          dt = $urandom_range(0, 1048575);
        end
        send_tick(tgt, sen, dt);
      end
      calm = 1'b0;
    end
  endtask

  initial begin
    fails = 0;
    calm = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_bus.valid = 1'b0;
    in_bus.data = '0;
    kp = 0;
    ki = 0;
    kd = 0;
    dband = 9;
    dmax = 250;
    dmin = 0;
    rlim = 20 << 16;
    hist[0] = 0;
    hist[1] = 0;
    hist[2] = 0;
    integ = 0;
    hdrive = 0;
    hsmooth = 0;
    wind = 0;
    skip = 0;
    mflag = 0;
    nflag = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed_extremes();
    test_random_phases();
    drain();
    repeat (20) @(posedge clk);
    if (fails == 0 && drive_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
`default_nettype wire
